[rtl/fcls_pkg.sv]
// Package with widths and decoder patterns of the frame sequencer.
`timescale 1ns / 1ps
`default_nettype none
package fcls_pkg;

    localparam int LfsrW    = 15;
    localparam int NumDec   = 6;
    localparam int InDataW  = 16;
    localparam int OutDataW = 8;

    typedef logic [LfsrW-1:0] t_lfsr;

    // Decoder patterns matched against the output half of the LFSR
    localparam t_lfsr DEC_PATTERN [NumDec] = '{
        15'd28574, 15'd18940, 15'd21292, 15'd30176, 15'd3706, 15'd32767
    };

    typedef struct packed {
        logic       dmc_irq;
        logic [7:0] data_byte;
        logic       status_read_n;
        logic       chip_reset;
        logic       mode_write;
        logic       phase_level;
    } t_in_item;

    typedef struct packed {
        logic status_bit;
        logic status_drive;
        logic irq_line;
        logic half_clock;
        logic quarter_clock;
    } t_out_item;

endpackage
`default_nettype wire

[rtl/frame_counter_lfsr_sequencer_unit.sv]
// Frame sequencer top level: LFSR, pattern decoders, latches and result register.
`timescale 1ns / 1ps
`default_nettype none
// Half-clock frame sequencer. Every input transaction is one master clock
// phase; the block evaluates the 15-bit inverted LFSR, its six pattern
// decoders and the restart, rate and interrupt latches, and returns exactly
// one result transaction per input transaction. One transaction per cycle is
// sustained while results drain: the phase evaluation is combinational logic
// between the state registers and the result register, and the input is taken
// whenever the result register is empty or is being drained in the same cycle.
module frame_counter_lfsr_sequencer_unit
    import fcls_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    // [0] phase_level, [1] mode_write, [2] chip_reset, [3] status_read_n,
    // [11:4] data_byte, [12] dmc_irq, [15:13] unused
    input  wire  [InDataW-1:0]  s_axis_tdata,
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    // [0] quarter_clock, [1] half_clock, [2] irq_line, [3] status_drive,
    // [4] status_bit, [7:5] zero
    output logic [OutDataW-1:0] m_axis_tdata
);

    t_in_item  w_in;
    logic      w_accept;

    t_lfsr     r_shift_in,  n_shift_in;
    t_lfsr     r_shift_out, n_shift_out;
    logic      r_five_step, n_five_step;
    logic      r_inhibit,   n_inhibit;
    logic      r_frame_irq, n_frame_irq;
    logic      r_rate,      n_rate;
    logic      r_restart_l, n_restart_l;
    logic      r_restart_f, n_restart_f;
    logic      r_irq_stat,  n_irq_stat;
    logic      r_valid;
    t_out_item r_out,       n_out;

    logic [NumDec-1:0] w_dec;
    logic w_aclk, w_naclk, w_c13, w_c14, w_fb, w_ff1, w_z1, w_z2, w_any34;
    logic w_clr, w_ff2;

    assign w_in          = t_in_item'(s_axis_tdata[$bits(t_in_item)-1:0]);
    assign s_axis_tready = !r_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {{(OutDataW-$bits(t_out_item)){1'b0}}, r_out};

    always_comb begin
        w_aclk  = w_in.phase_level;
        w_naclk = !w_in.phase_level;
        for (int k = 0; k < NumDec; k++) begin
            w_dec[k] = (r_shift_out == DEC_PATTERN[k]);
        end
        w_c13 = !r_shift_out[13];
        w_c14 = !r_shift_out[14];
        w_fb  = !(w_c13 && w_c14) && (w_c13 || w_dec[5] || w_c14);

        // mode register and rate latch (rate samples the old mode)
        n_rate      = w_naclk ? !r_five_step : r_rate;
        n_five_step = w_in.mode_write ? w_in.data_byte[7] : r_five_step;
        n_inhibit   = w_in.mode_write ? w_in.data_byte[6] : r_inhibit;

        // restart logic
        w_ff1       = !r_restart_f && !(w_in.mode_write || w_in.chip_reset);
        n_restart_l = w_naclk ? w_ff1 : r_restart_l;
        n_restart_f = (w_aclk || n_restart_l) && !w_ff1;
        w_z1        = !n_restart_l;
        w_z2        = !(n_rate || n_restart_l);

        // load ones on a terminal pattern or restart, else shift in low phase
        w_any34 = w_dec[3] || w_dec[4] || w_z1;
        if (w_aclk) begin
            n_shift_in = r_shift_in;
        end else if (w_any34) begin
            n_shift_in = '1;
        end else begin
            n_shift_in = {~r_shift_out[LfsrW-2:0], w_fb};
        end
        n_shift_out = w_naclk ? ~n_shift_in : r_shift_out;

        // frame interrupt
        w_clr = !(w_in.chip_reset || n_inhibit || (w_in.phase_level && !w_in.status_read_n));
        w_ff2 = w_clr ? 1'b0 : !r_frame_irq;
        n_frame_irq = !(!n_five_step && w_dec[3]) && !w_ff2;
        n_irq_stat  = w_naclk ? n_frame_irq : r_irq_stat;

        n_out.quarter_clock = !(w_z2 || (|w_dec[4:0])) || w_aclk;
        n_out.half_clock    = !(w_z2 || w_dec[1] || w_dec[3] || w_dec[4]) || w_aclk;
        n_out.irq_line      = w_in.dmc_irq || w_ff2;
        n_out.status_drive  = w_in.status_read_n;
        n_out.status_bit    = w_in.status_read_n && !n_irq_stat;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_in  <= '0;
            r_shift_out <= '0;
            r_five_step <= 1'b0;
            r_inhibit   <= 1'b0;
            r_frame_irq <= 1'b0;
            r_rate      <= 1'b0;
            r_restart_l <= 1'b0;
            r_restart_f <= 1'b0;
            r_irq_stat  <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            if (w_accept) begin
                r_shift_in  <= n_shift_in;
                r_shift_out <= n_shift_out;
                r_five_step <= n_five_step;
                r_inhibit   <= n_inhibit;
                r_frame_irq <= n_frame_irq;
                r_rate      <= n_rate;
                r_restart_l <= n_restart_l;
                r_restart_f <= n_restart_f;
                r_irq_stat  <= n_irq_stat;
                r_valid     <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result payload needs no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

endmodule
`default_nettype wire

[rtl/fcls_checker.sv]
// Port-level checker for the frame sequencer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module fcls_checker
    import fcls_pkg::*;
(
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 s_axis_tvalid,
    input wire                 s_axis_tready,
    input wire [InDataW-1:0]   s_axis_tdata,
    input wire                 m_axis_tvalid,
    input wire                 m_axis_tready,
    input wire [OutDataW-1:0]  m_axis_tdata
);

    // an empty result register never stalls the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // every accepted transaction shows a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("accepted transaction produced no result");

    // status drive echoes the status read line of the accepted transaction
    a_drive_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (m_axis_tdata[3] == $past(s_axis_tdata[3])))
        else $error("status drive does not follow the accepted transaction");

    // status bit only while the status is driven
    a_status_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[4]) |-> m_axis_tdata[3])
        else $error("status bit set while not driven");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind frame_counter_lfsr_sequencer_unit fcls_checker u_fcls_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
